[rtl/sle_pkg.sv]
package sle_pkg;

  localparam int CNT_W = 6;

  localparam logic [1:0] CH_ECHO = 2'd0;
  localparam logic [1:0] CH_LINE = 2'd1;
  localparam logic [1:0] CH_END  = 2'd2;

  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_SP  = 8'd32;
  localparam logic [7:0] BYTE_DEL = 8'd127;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd32;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       allowed;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       channel;
    logic [7:0]       out_byte;
    logic [CNT_W-1:0] line_length;
    logic             last;
  } out_word_t;

endpackage

[rtl/sle_ram.sv]
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/serial_line_editor.sv]
// The first result word is loaded into the output register from the state entered on
// acceptance of its input word; when a full line with characters ends, the line store is read first.
// Input stalls until every word of a byte is loaded: the echo, the erase sequence of a
// backspace, or the stored bytes and end word of a carriage return; each stored byte
// costs one line store read plus one load. An output stall holds the pending word.
// Reset (synchronous, rst_n low): line limit 32, fill count 0; line store not cleared.
module serial_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ECHO, S_ERASE, S_RD, S_LINE, S_ENDM
  } state_t;

  typedef enum logic [1:0] {K_ORD, K_BS, K_CR} kind_t;

  state_t           state_r;
  kind_t            kind_r;
  logic [7:0]       byte_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] idx_r;
  logic [1:0]       cnt_r;
  logic [CNT_W-1:0] limit_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic             in_acc;
  logic             is_bs;
  logic             is_cr;
  logic             take;
  logic [CNT_W-1:0] limit_eff;
  logic             full;
  logic             out_free;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic [CNT_W-1:0] idx_inc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign is_bs     = (in_word.rx_byte == BYTE_BS) || (in_word.rx_byte == BYTE_DEL);
  assign is_cr     = (in_word.rx_byte == BYTE_CR);
  assign take      = in_word.allowed || is_bs || is_cr;
  assign limit_eff = (limit_r < DEPTH_C) ? limit_r : DEPTH_C;
  assign full      = (fill_r >= limit_eff);
  assign ram_we    = in_acc && take && !is_bs && !is_cr && !full;
  assign ram_re    = (state_r == S_RD);
  assign idx_inc   = idx_r + CNT_W'(1);

  sle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_word.rx_byte),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          cnt_r <= '0;
          if (in_acc && take) begin
            byte_r <= in_word.rx_byte;
            if (is_cr) begin
              kind_r <= K_CR;
            end else if (is_bs) begin
              kind_r <= K_BS;
            end else begin
              kind_r <= K_ORD;
            end
            if (!full) begin
              state_r <= S_ECHO;
              if (!is_bs && !is_cr) begin
                fill_r <= fill_r + CNT_W'(1);
              end
            end else if (is_cr) begin
              state_r <= (fill_r == '0) ? S_ENDM : S_RD;
            end else if (is_bs && fill_r != '0) begin
              state_r <= S_ERASE;
            end
          end
        end
        S_ECHO: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.channel     <= CH_ECHO;
            out_r.out_byte    <= byte_r;
            out_r.line_length <= '0;
            out_r.last        <= (kind_r == K_ORD) || (kind_r == K_BS && fill_r == '0);
            case (kind_r)
              K_CR:    state_r <= (fill_r == '0) ? S_ENDM : S_RD;
              K_BS:    state_r <= (fill_r == '0) ? S_IDLE : S_ERASE;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_ERASE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.channel     <= CH_ECHO;
            out_r.out_byte    <= (cnt_r == 2'd1) ? BYTE_SP : BYTE_BS;
            out_r.line_length <= '0;
            out_r.last        <= (cnt_r == 2'd2);
            cnt_r             <= cnt_r + 2'd1;
            if (cnt_r == 2'd2) begin
              fill_r  <= fill_r - CNT_W'(1);
              state_r <= S_IDLE;
            end
          end
        end
        S_RD: begin
          state_r <= S_LINE;
        end
        S_LINE: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.channel     <= CH_LINE;
            out_r.out_byte    <= ram_rdata;
            out_r.line_length <= '0;
            out_r.last        <= 1'b0;
            idx_r             <= idx_inc;
            state_r           <= (idx_inc < fill_r) ? S_RD : S_ENDM;
          end
        end
        S_ENDM: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_r.channel     <= CH_END;
            out_r.out_byte    <= '0;
            out_r.line_length <= fill_r;
            out_r.last        <= 1'b1;
            fill_r            <= '0;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/sle_line_checker.sv]
module sle_line_checker
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_word_t        out_word,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  out_word_t        editor_out_q[$];
  logic [7:0]       line_buf[LINE_DEPTH];
  int               fill;
  logic [CNT_W-1:0] line_limit;

  function automatic out_word_t mk_word(logic [1:0] ch, logic [7:0] b, int len);
    out_word_t w;
    w.channel     = ch;
    w.out_byte    = b;
    w.line_length = len[CNT_W-1:0];
    w.last        = 1'b0;
    return w;
  endfunction

  task automatic edit_line(input in_word_t w);
    out_word_t  burst[$];
    logic [7:0] c;
    logic       is_bs;
    logic       is_cr;
    logic       full;
    int         lim;
    c     = w.rx_byte;
    is_bs = (c == BYTE_BS) || (c == BYTE_DEL);
    is_cr = (c == BYTE_CR);
    lim   = (int'(line_limit) > LINE_DEPTH) ? LINE_DEPTH : int'(line_limit);
    full  = (fill >= lim);
    if (!(w.allowed || is_bs || is_cr)) return;
    if (!full) burst.push_back(mk_word(CH_ECHO, c, 0));
    if (is_cr) begin
      for (int i = 0; i < fill && i < LINE_DEPTH; i++)
        burst.push_back(mk_word(CH_LINE, line_buf[i], 0));
      burst.push_back(mk_word(CH_END, 8'd0, fill));
      fill = 0;
    end else if (is_bs) begin
      if (fill > 0) begin
        burst.push_back(mk_word(CH_ECHO, BYTE_BS, 0));
        burst.push_back(mk_word(CH_ECHO, BYTE_SP, 0));
        burst.push_back(mk_word(CH_ECHO, BYTE_BS, 0));
        fill--;
      end
    end else if (!full) begin
      if (fill < LINE_DEPTH) line_buf[fill] = c;
      fill = (fill + 1) & 6'h3f;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) editor_out_q.push_back(burst[i]);
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (editor_out_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word ch=%0d byte=%02h len=%0d last=%0b",
                 got.channel, got.out_byte, got.line_length, got.last);
      return;
    end
    want = editor_out_q.pop_front();
    if (got.channel !== want.channel || got.out_byte !== want.out_byte ||
        got.line_length !== want.line_length || got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch exp ch=%0d byte=%02h len=%0d last=%0b  got ch=%0d byte=%02h len=%0d last=%0b",
                 want.channel, want.out_byte, want.line_length, want.last,
                 got.channel, got.out_byte, got.line_length, got.last);
    end
  endtask

  initial begin
    errors     = 0;
    pending    = 0;
    fill       = 0;
    line_limit = LIMIT_RESET;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      editor_out_q.delete();
      fill       = 0;
      line_limit = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) line_limit = cfg_data;
      if (out_valid && !out_stall) check_word(out_word);
      if (in_valid && !in_stall) edit_line(in_word);
    end
    pending = editor_out_q.size();
  end

endmodule

[verif/tb_serial_line_editor.sv]
module tb_serial_line_editor
  import sle_pkg::*;
();

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  int               errors;
  int               pending;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               fed;

  always #1 clk = ~clk;

  serial_line_editor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sle_line_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic feed(input logic [7:0] b, input logic ok);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_word.rx_byte = b;
    in_word.allowed = ok;
    do @(posedge clk); while (in_stall);
    fed++;
  endtask

  task automatic drain(input int tail);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    drain(10);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_line();
    int len;
    int r;
    len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 70)      feed(8'($urandom_range(255)), 1'b1);
      else if (r < 82) feed($urandom_range(1) ? BYTE_BS : BYTE_DEL, 1'($urandom_range(1)));
      else             feed(8'($urandom_range(255)), 1'b0);
    end
    feed(BYTE_CR, 1'($urandom_range(1)));
  endtask

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    int phase_limit[4];
    phase_idle  = '{0, 86, 0, 36};
    phase_stall = '{0, 0, 86, 36};
    phase_limit = '{63, 32, $urandom_range(1, 31), $urandom_range(0, 63)};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    feed("a", 1'b1);
    feed(8'hff, 1'b1);
    feed(8'h00, 1'b1);
    feed("A", 1'b0);
    feed(BYTE_BS, 1'b0);
    feed(BYTE_DEL, 1'b1);
    feed(BYTE_BS, 1'b1);
    feed(BYTE_BS, 1'b1);
    feed(BYTE_CR, 1'b0);
    feed("k", 1'b1);
    feed("m", 1'b1);
    feed("n", 1'b1);
    write_limit(6'd1);
    feed("w", 1'b1);
    feed(BYTE_CR, 1'b1);
    write_limit(6'd2);
    feed("x", 1'b1);
    feed("y", 1'b1);
    feed("z", 1'b1);
    feed(BYTE_DEL, 1'b0);
    feed("q", 1'b1);
    feed(BYTE_CR, 1'b1);
    write_limit(6'd0);
    feed("a", 1'b1);
    feed(BYTE_BS, 1'b1);
    feed(BYTE_CR, 1'b1);

    for (int p = 0; p < 4; p++) begin
      write_limit(CNT_W'(phase_limit[p]));
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      fed = 0;
      while (fed < 45) random_line();
      if (p == 1) drain(0);
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain(20);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
